### design/prpi_pkg.sv
// Package for the polar ray profile interpolator: request/result structs,
// function and status codes, ray entry type and CORDIC arctangent table.
// No dependencies.
`default_nettype none
package prpi_pkg;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_OFFGRID = 2'd3;

  localparam int CORDIC_STEPS = 28;
  localparam int CFG_WIDTH = 19;
  localparam logic CFG_DIAMETER = 1'b0;
  localparam logic CFG_PITCH    = 1'b1;
  localparam logic [18:0] DIAMETER_RESET = 19'd300000;
  localparam logic [15:0] PITCH_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        fit_angle;
    logic               fit_valid;
    logic signed [31:0] coef_quad;
    logic signed [31:0] coef_lin;
    logic signed [31:0] coef_const;
    logic [10:0]        column;
    logic [10:0]        row;
  } request_t;

  typedef struct packed {
    logic signed [31:0] height_nm;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } coef_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
        5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
        5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
        5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
        5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
        5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
        5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

### design/prpi_ray_mem.sv
// Ray table storage: angle memory and coefficient memory, one write port and
// one registered read port each. Depends on prpi_pkg.
`default_nettype none
module prpi_ray_mem #(
  parameter int MAX_RAYS   = 64,
  parameter int ANGLE_BITS = 16,
  parameter int AW         = 6
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [AW-1:0]             waddr,
  input  wire [ANGLE_BITS-1:0]     wangle,
  input  prpi_pkg::coef_t          wcoef,
  input  wire [AW-1:0]             raddr,
  output logic [ANGLE_BITS-1:0]    rangle,
  output prpi_pkg::coef_t          rcoef
);
  logic [ANGLE_BITS-1:0] angle_mem [MAX_RAYS];
  prpi_pkg::coef_t       coef_mem  [MAX_RAYS];

  always_ff @(posedge clk) begin
    if (we) begin
      angle_mem[waddr] <= wangle;
      coef_mem[waddr]  <= wcoef;
    end
    rangle <= angle_mem[raddr];
    rcoef  <= coef_mem[raddr];
  end
endmodule
`default_nettype wire

### design/prpi_sqrt.sv
// Iterative restoring square root, one result bit per cycle.
// No dependencies.
`default_nettype none
module prpi_sqrt #(
  parameter int IW = 64
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              go,
  input  wire [IW-1:0]     value,
  output logic             done,
  output logic [IW/2-1:0]  root
);
  localparam int CW = $clog2(IW/2 + 1);
  logic [IW-1:0]   rem;
  logic [IW-1:0]   src;
  logic [IW/2+1:0] trial;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [IW/2+1:0] rem_hi;

  always_comb begin
    rem_hi = {rem[IW/2-1:0], src[IW-1:IW-2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(IW/2);
        rem  <= '0;
        src  <= value;
        root <= '0;
      end else if (busy) begin
        src <= {src[IW-3:0], 2'b00};
        if (rem_hi >= trial) begin
          rem  <= IW'(rem_hi - trial);
          root <= {root[IW/2-2:0], 1'b1};
        end else begin
          rem  <= IW'(rem_hi);
          root <= {root[IW/2-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/prpi_divider.sv
// Iterative restoring divider for the interpolation fraction:
// quotient = floor(num * 2^16 / den), 17 bits, one bit per cycle.
// No dependencies.
`default_nettype none
module prpi_divider #(
  parameter int W = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          go,
  input  wire [W-1:0]  num,
  input  wire [W-1:0]  den,
  output logic         done,
  output logic [16:0]  quo
);
  logic [W:0]    rem;
  logic [W-1:0]  dv;
  logic [4:0]    cnt;
  logic          busy;
  logic [W+1:0]  sh;

  assign sh = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 5'd17;
        // num <= den, so first quotient bit comes from num itself
        rem  <= {1'b0, num};
        dv   <= den;
        quo  <= '0;
      end else if (busy) begin
        if (cnt == 5'd17) begin
          if (rem >= {1'b0, dv}) begin
            rem <= rem - {1'b0, dv};
            quo <= 17'd1;
          end
        end else if (sh >= {2'b00, dv}) begin
          rem <= (W+1)'(sh - {2'b00, dv});
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= sh[W:0];
          quo <= {quo[15:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/polar_ray_profile_interpolator.sv
// Top level of the polar ray profile interpolator: command sequencer, CORDIC,
// height arithmetic. Depends on prpi_pkg, prpi_ray_mem, prpi_sqrt, prpi_divider.
//
//  channel   | signals                         | handshake
//  ----------+---------------------------------+-------------------------------
//  request   | start, busy, req                | taken when start & !busy
//  result    | result_strobe, result           | one cycle, cannot be held off
//  config    | cfg_we, cfg_index, cfg_data     | written on every cfg_we edge
//
// A clear, an ignored code or a skipped load leaves the sequencer idle. A load shifts
// the table one entry at a time (memory read, then compare and write), for
// each of the two rays.
// A query takes 19 half-size division steps, the square root, up to 28
// CORDIC steps, a bracket scan of one table read per ray, the divider and
// the height arithmetic; the single table read port makes the scan read
// one ray at a time.
// Reset: synchronous, clears ray count, sequencer, strobes and config registers to defaults.
// The ray table holds garbage after reset; entries past the count are never used.
// Busy stays high until the request is done; results are never stalled.
`default_nettype none
module polar_ray_profile_interpolator #(
  parameter int MAX_RAYS       = 64,
  parameter int MAX_HALF_CELLS = 1023,
  parameter int ANGLE_BITS     = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  prpi_pkg::request_t             req,
  output logic                           result_strobe,
  output prpi_pkg::result_t              result,
  input  wire                            cfg_we,
  input  wire                            cfg_index,
  input  wire [prpi_pkg::CFG_WIDTH-1:0]  cfg_data
);
  localparam int AW  = $clog2(MAX_RAYS);
  localparam int CNW = $clog2(MAX_RAYS + 1);
  localparam int HW  = $clog2(MAX_HALF_CELLS + 1);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic signed [47:0] HLIM = 48'sd70368744177663;

  // sequencer codes
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INS_RD   = 5'd1;
  localparam logic [4:0] S_INS_CMP  = 5'd2;
  localparam logic [4:0] S_HN       = 5'd3;
  localparam logic [4:0] S_XY       = 5'd4;
  localparam logic [4:0] S_SQ       = 5'd5;
  localparam logic [4:0] S_R2       = 5'd6;
  localparam logic [4:0] S_SQRT     = 5'd7;
  localparam logic [4:0] S_CORD     = 5'd8;
  localparam logic [4:0] S_SCAN_RD  = 5'd9;
  localparam logic [4:0] S_SCAN     = 5'd10;
  localparam logic [4:0] S_RAY_RD   = 5'd11;
  localparam logic [4:0] S_RAY_M1   = 5'd12;
  localparam logic [4:0] S_RAY_M2   = 5'd13;
  localparam logic [4:0] S_RAY_SUM  = 5'd14;
  localparam logic [4:0] S_DIV      = 5'd15;
  localparam logic [4:0] S_MIX      = 5'd16;
  localparam logic [4:0] S_OUT      = 5'd17;
  localparam logic [4:0] S_HNDIV    = 5'd18;
  localparam logic [4:0] S_INS_WAIT = 5'd19;

  logic [4:0] state;
  logic [18:0] diameter;
  logic [15:0] pitch;
  logic [CNW-1:0] ray_count;

  prpi_pkg::request_t rq;
  logic second;                       // inserting the opposite ray
  logic [ANGLE_BITS-1:0] ins_angle;
  prpi_pkg::coef_t ins_coef;
  logic [AW:0] pos;                   // insertion slot walks down

  // memory ports
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [ANGLE_BITS-1:0] mem_wangle, mem_rangle;
  prpi_pkg::coef_t mem_wcoef, mem_rcoef;

  prpi_ray_mem #(.MAX_RAYS(MAX_RAYS), .ANGLE_BITS(ANGLE_BITS), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wangle(mem_wangle),
    .wcoef(mem_wcoef), .raddr(mem_raddr), .rangle(mem_rangle), .rcoef(mem_rcoef)
  );

  // query datapath registers
  logic [HW-1:0] hn;
  logic [19:0] hn_q;                  // running quotient for half size
  logic [19:0] hn_rem;
  logic [4:0] hn_cnt;
  logic [19:0] hn_ceil;
  logic signed [27:0] x, y;
  logic [55:0] xx, yy;
  logic [56:0] r2;
  logic [31:0] rq8;
  logic sq_go, sq_done;
  logic [31:0] sq_root;
  logic signed [60:0] cx, cy;
  logic [31:0] acc;
  logic [4:0] ci;
  logic [ANGLE_BITS-1:0] theta;
  logic [AW:0] hi;
  logic [AW-1:0] hw_idx;
  logic [ANGLE_BITS-1:0] lo_ang, hw_ang;
  logic phase;                        // 0 = low ray, 1 = high ray
  logic signed [63:0] p_quad_hi, p_quad_lo, p_lin;
  logic signed [47:0] zlo, zhi;
  logic [ANGLE_BITS-1:0] span, off;
  logic dv_go, dv_done;
  logic [16:0] frac;
  logic signed [49:0] dz;
  logic signed [68:0] prod;

  // radius is only taken inside the wafer, so r2 stays below 2^36
  prpi_sqrt #(.IW(64)) u_sqrt (
    .clk(clk), .rst(rst), .go(sq_go), .value({r2[47:0], 16'd0}),
    .done(sq_done), .root(sq_root)
  );

  prpi_divider #(.W(ANGLE_BITS)) u_div (
    .clk(clk), .rst(rst), .go(dv_go), .num(off), .den(span),
    .done(dv_done), .quo(frac)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      diameter <= prpi_pkg::DIAMETER_RESET;
      pitch    <= prpi_pkg::PITCH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == prpi_pkg::CFG_DIAMETER) diameter <= cfg_data;
      else pitch <= cfg_data[15:0];
    end
  end

  assign busy = (state != S_IDLE);

  // angle of the incoming fit scaled to ANGLE_BITS
  logic [ANGLE_BITS-1:0] fit_ang;
  always_comb begin
    if (ANGLE_BITS >= 16) fit_ang = ANGLE_BITS'({req.fit_angle, 8'd0} >> (24 - ANGLE_BITS));
    else fit_ang = ANGLE_BITS'(req.fit_angle >> (16 - ANGLE_BITS));
  end

  logic [ANGLE_BITS-1:0] theta_next;
  assign theta_next = ANGLE_BITS'((acc + (32'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS));

  // round the half-size quotient up when a remainder is left
  assign hn_ceil = hn_q + {19'd0, (hn_rem != '0)};

  // ray height terms for the current readout
  logic signed [47:0] zsum;
  logic signed [65:0] zfull;
  always_comb begin
    zfull = 66'(p_quad_hi) + 66'(p_quad_lo >>> 16) + 66'(p_lin >>> 16)
          + 66'($signed({ins_coef.c, 8'd0}));
    if (zfull > 66'(HLIM)) zsum = HLIM;
    else if (zfull < -66'(HLIM)) zsum = -HLIM;
    else zsum = zfull[47:0];
  end

  logic signed [52:0] zmix;
  logic signed [44:0] nm;
  assign zmix = 53'(zlo) + 53'(prod >>> 16);
  assign nm   = 45'((zmix + 53'sd128) >>> 8);

  logic signed [60:0] sx, sy;
  assign sx = cy >>> ci;
  assign sy = cx >>> ci;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ray_count     <= '0;
      result_strobe <= 1'b0;
      mem_we        <= 1'b0;
      sq_go         <= 1'b0;
      dv_go         <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      mem_we        <= 1'b0;
      sq_go         <= 1'b0;
      dv_go         <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            rq <= req;
            case (req.func)
              prpi_pkg::FUNC_CLEAR: ray_count <= '0;
              prpi_pkg::FUNC_LOAD: begin
                if (req.fit_valid && (32'(ray_count) + 32'd2 <= 32'(MAX_RAYS))) begin
                  second    <= 1'b0;
                  ins_angle <= fit_ang;
                  ins_coef  <= '{a: req.coef_quad, b: req.coef_lin, c: req.coef_const};
                  pos       <= (AW+1)'(ray_count);
                  mem_raddr <= AW'(ray_count - 1'b1);
                  state     <= S_INS_RD;
                end
              end
              prpi_pkg::FUNC_QUERY: begin
                hn_q   <= '0;
                hn_rem <= '0;
                hn_cnt <= 5'd19;
                state  <= S_HNDIV;
              end
              default: ;
            endcase
          end
        end
        // wait for the registered read of the entry below the slot
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          if (pos != '0 && mem_rangle > ins_angle) begin
            mem_we     <= 1'b1;
            mem_waddr  <= pos[AW-1:0];
            mem_wangle <= mem_rangle;
            mem_wcoef  <= mem_rcoef;
            pos        <= pos - 1'b1;
            mem_raddr  <= AW'(pos - 2'd2);
            state      <= S_INS_RD;
          end else begin
            mem_we     <= 1'b1;
            mem_waddr  <= pos[AW-1:0];
            mem_wangle <= ins_angle;
            mem_wcoef  <= ins_coef;
            ray_count  <= ray_count + 1'b1;
            if (!second) begin
              // advance to the opposite ray; its first read waits for this write
              second      <= 1'b1;
              ins_angle   <= ins_angle + HALF_TURN;
              ins_coef.b  <= (ins_coef.b == 32'sh80000000) ? 32'sh7FFFFFFF : -ins_coef.b;
              pos         <= (AW+1)'(ray_count + 1'b1);
              state       <= S_INS_WAIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        // hold the read of the top entry until the first ray has landed
        S_INS_WAIT: begin
          mem_raddr <= AW'(pos - 1'b1);
          state     <= S_INS_RD;
        end
        // half size: ceil(D / 2P) by restoring division, one bit a cycle
        S_HNDIV: begin
          if (pitch == '0) begin
            hn    <= HW'(MAX_HALF_CELLS);
            state <= S_XY;
          end else if (hn_cnt == '0) begin
            if (hn_ceil > 20'(MAX_HALF_CELLS)) hn <= HW'(MAX_HALF_CELLS);
            else hn <= HW'(hn_ceil);
            state <= S_XY;
          end else begin
            if ({hn_rem[18:0], diameter[hn_cnt - 5'd1]} >= {3'd0, pitch, 1'b0}) begin
              hn_rem <= {hn_rem[18:0], diameter[hn_cnt - 5'd1]} - {3'd0, pitch, 1'b0};
              hn_q   <= {hn_q[18:0], 1'b1};
            end else begin
              hn_rem <= {hn_rem[18:0], diameter[hn_cnt - 5'd1]};
              hn_q   <= {hn_q[18:0], 1'b0};
            end
            hn_cnt <= hn_cnt - 1'b1;
          end
        end
        S_XY: begin
          if (32'(rq.column) > 32'(hn) * 2 || 32'(rq.row) > 32'(hn) * 2) begin
            result_strobe <= 1'b1;
            result        <= '{height_nm: '0, status: prpi_pkg::ST_OFFGRID};
            state         <= S_IDLE;
          end else begin
            x     <= 28'($signed({1'b0, rq.column}) - $signed({1'b0, hn})) * $signed({1'b0, pitch});
            y     <= 28'($signed({1'b0, rq.row}) - $signed({1'b0, hn})) * $signed({1'b0, pitch});
            state <= S_SQ;
          end
        end
        S_SQ: begin
          xx    <= 56'(x * x);
          yy    <= 56'(y * y);
          state <= S_R2;
        end
        S_R2: begin
          r2    <= 57'(xx) + 57'(yy);
          state <= S_OUT;
          phase <= 1'b0;
        end
        S_OUT: begin
          if ({r2, 2'b00} > 59'(diameter) * 59'(diameter)) begin
            result_strobe <= 1'b1;
            result        <= '{height_nm: '0, status: prpi_pkg::ST_OUTSIDE};
            state         <= S_IDLE;
          end else if (ray_count == '0) begin
            result_strobe <= 1'b1;
            result        <= '{height_nm: '0, status: prpi_pkg::ST_EMPTY};
            state         <= S_IDLE;
          end else begin
            sq_go <= 1'b1;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            rq8 <= sq_root;
            ci  <= '0;
            if (x < 0) begin
              cx  <= 61'(-x) <<< 20;
              cy  <= 61'(-y) <<< 20;
              acc <= 32'h80000000;
            end else begin
              cx  <= 61'(x) <<< 20;
              cy  <= 61'(y) <<< 20;
              acc <= '0;
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (x == 0 && y == 0) begin
            theta <= '0;
            hi <= '0; mem_raddr <= '0; state <= S_SCAN_RD;
          end else if (ci == 5'(prpi_pkg::CORDIC_STEPS) || cy == 0) begin
            theta <= theta_next;
            hi <= '0; mem_raddr <= '0; state <= S_SCAN_RD;
          end else begin
            if (cy > 0) begin
              cx <= cx + sx; cy <= cy - sy; acc <= acc + prpi_pkg::atan_turn(ci);
            end else begin
              cx <= cx - sx; cy <= cy + sy; acc <= acc - prpi_pkg::atan_turn(ci);
            end
            ci <= ci + 1'b1;
          end
        end
        S_SCAN_RD: state <= S_SCAN;
        S_SCAN: begin
          if (hi < (AW+1)'(ray_count) && mem_rangle < theta) begin
            hi        <= hi + 1'b1;
            mem_raddr <= AW'(hi + 1'b1);
            state     <= S_SCAN_RD;
          end else begin
            hw_idx    <= (hi == (AW+1)'(ray_count)) ? '0 : hi[AW-1:0];
            mem_raddr <= (hi == '0) ? AW'(ray_count - 1'b1) : AW'(hi - 1'b1);
            phase     <= 1'b0;
            state     <= S_RAY_RD;
          end
        end
        S_RAY_RD: state <= S_RAY_M1;
        S_RAY_M1: begin
          ins_coef <= mem_rcoef;
          if (!phase) lo_ang <= mem_rangle; else hw_ang <= mem_rangle;
          state <= S_RAY_M2;
        end
        S_RAY_M2: begin
          p_quad_hi <= 64'(ins_coef.a * $signed({1'b0, r2[35:16]}));
          p_quad_lo <= 64'(ins_coef.a * $signed({1'b0, r2[15:0]}));
          p_lin     <= 64'(ins_coef.b * $signed({1'b0, rq8}));
          state     <= S_RAY_SUM;
        end
        S_RAY_SUM: begin
          if (!phase) begin
            zlo       <= zsum;
            phase     <= 1'b1;
            mem_raddr <= hw_idx;
            state     <= S_RAY_RD;
          end else begin
            zhi <= zsum;
            span <= hw_ang - lo_ang;
            off  <= ((theta - lo_ang) > (hw_ang - lo_ang)) ? (hw_ang - lo_ang)
                                                            : (theta - lo_ang);
            dv_go <= (hw_ang != lo_ang);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (span == '0 || dv_done) begin
            dz    <= 50'(zhi) - 50'(zlo);
            state <= S_MIX;
          end
        end
        S_MIX: begin
          if (phase) begin
            // zero span gives fraction zero
            prod  <= 69'(dz * $signed({1'b0, (span == '0) ? 17'd0 : frac}));
            phase <= 1'b0;
          end else begin
            result_strobe <= 1'b1;
            result.status <= prpi_pkg::ST_VALID;
            if (nm > 45'sh7FFFFFFF) result.height_nm <= 32'sh7FFFFFFF;
            else if (nm < -45'sh80000000) result.height_nm <= 32'sh80000000;
            else result.height_nm <= nm[31:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ray_count) <= 32'(MAX_RAYS)) else $error("ray count over table size");
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> !busy) else $error("result shown while still busy");
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> $past(busy)) else $error("table write outside a request");
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.status != prpi_pkg::ST_VALID |-> result.height_nm == 0)
    else $error("nonzero height with error status");
`endif
endmodule
`default_nettype wire
